// ===== rtl/pbi_pkg.sv =====
// Package for the padded bucket index builder.
// Request, status and config codes, sizes, divider types, a coordinate helper.
// Has no dependencies.
`default_nettype none

package pbi_pkg;

	localparam int MAX_OBJECTS = 1024;
	localparam int MAX_BUCKETS = 1024;
	localparam int MAX_CELLS   = 4096;
	localparam int COORD_W     = 24;
	localparam int DIV_W       = 25;

	typedef enum logic [1:0] {
		REQ_ADD      = 2'd0,
		REQ_FINALIZE = 2'd1,
		REQ_READ_ROW = 2'd2,
		REQ_READ_CELL = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_OVFL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_BUCKET_WIDTH = 2'd0,
		CFG_BLOCK_SIZE   = 2'd1,
		CFG_LENGTH       = 2'd2,
		CFG_NONE         = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [15:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
		if (v > 26'sd8388607)
			return 24'h7FFFFF;
		else if (v < -26'sd8388608)
			return 24'h800000;
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/padded_bucket_index_build.sv =====
// Padded bucket index builder: object store, finalize sequencer and read port.
// Depends on pbi_pkg and pbi_div.
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   req_type obj_center_x obj_half_width read_index
// out      out  out_valid/out_stall status value bucket_count level_length
// cfg      in   cfg_valid/cfg_ready cfg_index cfg_data
//
// Add: result passes S_EMIT to the output register. Reads: one synchronous memory read
// first, skipped on a range error. Finalize: bucket count divide, clear, count pass,
// prefix sum, fill pass; the divider is shared by the bucket count and every span end.
// One request at a time; the next is taken once the result sits in the output register.
// Reset clears control state; the memories need no clearing.
`default_nettype none

module padded_bucket_index_build
	import pbi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [23:0] obj_center_x,
	input  wire logic [15:0] obj_half_width,
	input  wire logic [12:0] read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [12:0]      value,
	output logic [10:0]      bucket_count,
	output logic [23:0]      level_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_EMIT    = 17'h00002,
		S_RD_ROW  = 17'h00004,
		S_RD_CELL = 17'h00008,
		S_NB_DIV  = 17'h00010,
		S_EMPTY1  = 17'h00020,
		S_CLR     = 17'h00040,
		S_OBJ_ADDR = 17'h00080,
		S_OBJ_DATA = 17'h00100,
		S_L_DIV   = 17'h00200,
		S_R_DIV   = 17'h00400,
		S_CNT_RD  = 17'h00800,
		S_CNT_WR  = 17'h01000,
		S_PRE_RD  = 17'h02000,
		S_PRE_WR  = 17'h04000,
		S_FILL_RD = 17'h08000,
		S_FILL_WR = 17'h10000
	} state_t;

	state_t state_q;

	logic [23:0] ctr_mem  [MAX_OBJECTS];
	logic [15:0] hw_mem   [MAX_OBJECTS];
	logic [12:0] cnt_mem  [MAX_BUCKETS];
	logic [12:0] cur_mem  [MAX_BUCKETS];
	logic [12:0] row_mem  [MAX_BUCKETS + 1];
	logic [9:0]  cell_mem [MAX_CELLS];

	logic [23:0] ctr_rd, row_unused_c;
	logic [15:0] hw_rd;
	logic [12:0] cnt_rd, cur_rd, row_rd;
	logic [9:0]  cell_rd;

	logic [15:0] bw_q, bs_q;
	logic [23:0] len_q;
	logic [10:0] obj_cnt_q;
	logic [23:0] lle_q, gre_q;
	logic [10:0] held_q;
	logic [12:0] total_q;
	logic [24:0] origin_q;
	logic [10:0] nb_q;
	logic [9:0]  obj_i_q;
	logic [9:0]  b_q;
	logic [24:0] lo_q;
	logic [9:0]  hi_q;
	logic [23:0] right_q;
	logic [12:0] rs_q;
	logic        pass_q;
	logic        ovfl_q;

	logic [1:0]  res_status_q;
	logic [12:0] res_value_q;
	logic [10:0] res_nb_q;
	logic [23:0] res_len_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [12:0] out_value_q;
	logic [10:0] out_nb_q;
	logic [23:0] out_len_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        in_acc;
	logic [15:0] bw_eff;
	logic [24:0] origin_c;
	logic [23:0] add_l, add_r, obj_l, obj_r;
	logic [23:0] len_derived;
	logic        len_nonpos;
	logic [10:0] nbm1;
	logic [25:0] q_p1;
	logic [9:0]  hi_c;
	logic [24:0] lo_c;
	logic [13:0] pre_sum;
	logic [12:0] pre_s;
	logic        pre_sat;
	logic        last_obj;
	logic        last_b;
	logic        fill_ok;

	logic        row_we;
	logic [10:0] row_wa, row_ra;
	logic [12:0] row_wd;
	logic        cnt_we;
	logic [12:0] cnt_wd;
	logic        cur_we;
	logic [12:0] cur_wd;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign bw_eff   = (bw_q == 16'd0) ? 16'd1 : bw_q;
	assign origin_c = $signed({lle_q[23], lle_q}) - $signed({9'd0, bs_q});
	assign add_l = sat_coord($signed({{2{obj_center_x[23]}}, obj_center_x}) -
		$signed({10'd0, obj_half_width}));
	assign add_r = sat_coord($signed({{2{obj_center_x[23]}}, obj_center_x}) +
		$signed({10'd0, obj_half_width}));
	assign obj_l = sat_coord($signed({{2{ctr_rd[23]}}, ctr_rd}) - $signed({10'd0, hw_rd}));
	assign obj_r = sat_coord($signed({{2{ctr_rd[23]}}, ctr_rd}) + $signed({10'd0, hw_rd}));
	assign len_derived = sat_coord($signed({{2{gre_q[23]}}, gre_q}) +
		$signed({8'd0, bs_q, 2'd0}) + $signed({10'd0, bs_q}));
	assign len_nonpos = len_q[23] || (len_q == 24'd0);

	assign nbm1     = nb_q - 11'd1;
	assign q_p1     = {1'b0, div_rsp.quotient} + 26'd1;
	assign hi_c     = (q_p1 > {15'd0, nbm1}) ? nbm1[9:0] : q_p1[9:0];
	assign lo_c     = (div_rsp.quotient == 25'd0) ? 25'd0 : div_rsp.quotient - 25'd1;
	assign pre_sum  = {1'b0, rs_q} + {1'b0, cnt_rd};
	assign pre_sat  = pre_sum > 14'(MAX_CELLS);
	assign pre_s    = pre_sat ? 13'(MAX_CELLS) : pre_sum[12:0];
	assign last_obj = ({1'b0, obj_i_q} == (obj_cnt_q - 11'd1));
	assign last_b   = (b_q == hi_q);
	assign fill_ok  = cur_rd < row_rd;
	assign row_unused_c = '0;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = bw_eff;
		case (state_q)
			S_IDLE: begin
				div_req.start = in_acc && (req_t'(req_type) == REQ_FINALIZE) &&
					(obj_cnt_q != 11'd0);
				div_req.dividend = 25'($signed({{2{gre_q[23]}}, gre_q}) -
					$signed({origin_c[24], origin_c}));
			end
			S_OBJ_DATA: begin
				div_req.start = 1'b1;
				div_req.dividend = 25'($signed({{2{obj_l[23]}}, obj_l}) -
					$signed({origin_q[24], origin_q}));
			end
			S_L_DIV: begin
				div_req.start = div_rsp.done;
				div_req.dividend = 25'($signed({{2{right_q[23]}}, right_q}) -
					$signed({origin_q[24], origin_q}));
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	pbi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		row_we = 1'b0;
		row_wa = {1'b0, b_q} + 11'd1;
		row_wd = '0;
		row_ra = (state_q == S_IDLE) ? read_index[10:0] : ({1'b0, b_q} + 11'd1);
		cnt_we = 1'b0;
		cnt_wd = '0;
		cur_we = 1'b0;
		cur_wd = rs_q;
		case (state_q)
			S_IDLE: begin
				row_we = in_acc && (req_t'(req_type) == REQ_FINALIZE) && (obj_cnt_q == 11'd0);
				row_wa = 11'd0;
			end
			S_EMPTY1: begin
				row_we = 1'b1;
				row_wa = 11'd1;
			end
			S_CLR: begin
				row_we = 1'b1;
				row_wa = 11'd0;
				cnt_we = 1'b1;
			end
			S_CNT_WR: begin
				cnt_we = 1'b1;
				cnt_wd = cnt_rd + 13'd1;
			end
			S_PRE_WR: begin
				row_we = 1'b1;
				row_wd = pre_s;
				cur_we = 1'b1;
			end
			S_FILL_WR: begin
				cur_we = fill_ok;
				cur_wd = cur_rd + 13'd1;
			end
			default: begin
				row_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && (req_t'(req_type) == REQ_ADD) && (obj_cnt_q < 11'(MAX_OBJECTS))) begin
			ctr_mem[obj_cnt_q[9:0]] <= obj_center_x;
			hw_mem[obj_cnt_q[9:0]]  <= obj_half_width;
		end
		ctr_rd <= ctr_mem[obj_i_q];
		hw_rd  <= hw_mem[obj_i_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[b_q] <= cnt_wd;
		cnt_rd <= cnt_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (cur_we)
			cur_mem[b_q] <= cur_wd;
		cur_rd <= cur_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[row_wa] <= row_wd;
		row_rd <= row_mem[row_ra];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FILL_WR) && fill_ok)
			cell_mem[cur_rd[11:0]] <= obj_i_q;
		cell_rd <= cell_mem[read_index[11:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bw_q         <= 16'd1920;
			bs_q         <= 16'd480;
			len_q        <= '0;
			obj_cnt_q    <= '0;
			lle_q        <= '0;
			gre_q        <= '0;
			held_q       <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BUCKET_WIDTH: bw_q  <= cfg_data[15:0];
					CFG_BLOCK_SIZE:   bs_q  <= cfg_data[15:0];
					CFG_LENGTH:       len_q <= cfg_data;
					default:          bw_q  <= bw_q;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != S_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= ST_OK;
						res_value_q  <= '0;
						res_nb_q     <= '0;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
						case (req_t'(req_type))
							REQ_ADD: begin
								if (obj_cnt_q >= 11'(MAX_OBJECTS)) begin
									res_status_q <= ST_FULL;
								end else begin
									res_value_q <= {2'd0, obj_cnt_q};
									if (obj_cnt_q == 11'd0 || $signed(add_l) < $signed(lle_q))
										lle_q <= add_l;
									if (obj_cnt_q == 11'd0 || $signed(add_r) > $signed(gre_q))
										gre_q <= add_r;
									obj_cnt_q <= obj_cnt_q + 11'd1;
								end
							end
							REQ_FINALIZE: begin
								ovfl_q <= 1'b0;
								if (obj_cnt_q == 11'd0) begin
									state_q <= S_EMPTY1;
								end else begin
									origin_q <= origin_c;
									if (len_nonpos)
										len_q <= len_derived;
									state_q <= S_NB_DIV;
								end
							end
							REQ_READ_ROW: begin
								if (held_q == 11'd0) begin
									if (read_index != 13'd0)
										res_status_q <= ST_RANGE;
								end else if (read_index <= {2'd0, held_q}) begin
									state_q <= S_RD_ROW;
								end else begin
									res_status_q <= ST_RANGE;
								end
							end
							default: begin
								if (read_index < total_q)
									state_q <= S_RD_CELL;
								else
									res_status_q <= ST_RANGE;
							end
						endcase
					end
				end
				S_RD_ROW: begin
					res_value_q <= row_rd;
					state_q     <= S_EMIT;
				end
				S_RD_CELL: begin
					res_value_q <= {3'd0, cell_rd};
					state_q     <= S_EMIT;
				end
				S_EMPTY1: begin
					held_q   <= 11'd1;
					total_q  <= '0;
					res_nb_q <= 11'd1;
					res_len_q <= len_q;
					state_q  <= S_EMIT;
				end
				S_NB_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient >= 25'(MAX_BUCKETS - 1)) begin
							nb_q   <= 11'(MAX_BUCKETS);
							ovfl_q <= 1'b1;
						end else begin
							nb_q <= div_rsp.quotient[10:0] + 11'd2;
						end
						b_q     <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if ({1'b0, b_q} == nbm1) begin
						obj_i_q <= '0;
						pass_q  <= 1'b0;
						state_q <= S_OBJ_ADDR;
					end else begin
						b_q <= b_q + 10'd1;
					end
				end
				S_OBJ_ADDR: begin
					state_q <= S_OBJ_DATA;
				end
				S_OBJ_DATA: begin
					right_q <= obj_r;
					state_q <= S_L_DIV;
				end
				S_L_DIV: begin
					if (div_rsp.done) begin
						lo_q    <= lo_c;
						state_q <= S_R_DIV;
					end
				end
				S_R_DIV: begin
					if (div_rsp.done) begin
						hi_q <= hi_c;
						if (lo_q > {15'd0, hi_c}) begin
							if (last_obj) begin
								b_q     <= '0;
								rs_q    <= '0;
								state_q <= pass_q ? S_EMIT : S_PRE_RD;
								if (pass_q) begin
									held_q       <= nb_q;
									total_q      <= rs_q;
									res_nb_q     <= nb_q;
									res_len_q    <= len_q;
									res_status_q <= ovfl_q ? ST_OVFL : ST_OK;
								end
							end else begin
								obj_i_q <= obj_i_q + 10'd1;
								state_q <= S_OBJ_ADDR;
							end
						end else begin
							b_q     <= lo_q[9:0];
							state_q <= pass_q ? S_FILL_RD : S_CNT_RD;
						end
					end
				end
				S_CNT_RD: begin
					state_q <= S_CNT_WR;
				end
				S_CNT_WR: begin
					if (!last_b) begin
						b_q     <= b_q + 10'd1;
						state_q <= S_CNT_RD;
					end else if (last_obj) begin
						b_q     <= '0;
						rs_q    <= '0;
						state_q <= S_PRE_RD;
					end else begin
						obj_i_q <= obj_i_q + 10'd1;
						state_q <= S_OBJ_ADDR;
					end
				end
				S_PRE_RD: begin
					state_q <= S_PRE_WR;
				end
				S_PRE_WR: begin
					rs_q <= pre_s;
					if (pre_sat)
						ovfl_q <= 1'b1;
					if ({1'b0, b_q} == nbm1) begin
						obj_i_q <= '0;
						pass_q  <= 1'b1;
						state_q <= S_OBJ_ADDR;
					end else begin
						b_q     <= b_q + 10'd1;
						state_q <= S_PRE_RD;
					end
				end
				S_FILL_RD: begin
					state_q <= S_FILL_WR;
				end
				S_FILL_WR: begin
					if (!last_b) begin
						b_q     <= b_q + 10'd1;
						state_q <= S_FILL_RD;
					end else if (last_obj) begin
						held_q       <= nb_q;
						total_q      <= rs_q;
						res_nb_q     <= nb_q;
						res_len_q    <= len_q;
						res_status_q <= ovfl_q ? ST_OVFL : ST_OK;
						state_q      <= S_EMIT;
					end else begin
						obj_i_q <= obj_i_q + 10'd1;
						state_q <= S_OBJ_ADDR;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_value_q  <= res_value_q;
						out_nb_q     <= res_nb_q;
						out_len_q    <= res_len_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign value        = out_value_q;
	assign bucket_count = out_nb_q;
	assign level_length = out_len_q | row_unused_c;

	assert property (@(posedge clk) disable iff (!arst_n)
		obj_cnt_q <= 11'(MAX_OBJECTS))
		else $error("object count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q <= 11'(MAX_BUCKETS)) && (total_q <= 13'(MAX_CELLS)))
		else $error("held index beyond table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |=> (out_valid || (state_q == S_EMIT)))
		else $error("result lost on emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FILL_WR) && fill_ok) |-> (cur_rd < 13'(MAX_CELLS)))
		else $error("cell write beyond store");

endmodule

`default_nettype wire

// ===== rtl/pbi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Uses pbi_pkg for the request and response types.
`default_nettype none

module pbi_div
	import pbi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic             busy_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [15:0]      rem_q;
	logic [15:0]      dsr_q;
	logic [DIV_W-1:0] dvd_q;
	logic [16:0]      trial;
	logic [16:0]      diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ===== dv/tb_padded_bucket_index_build.sv =====
// Testbench for padded_bucket_index_build: directed table then random phases of adds,
// finalize requests and reads, checked against table values or an in-bench predictor.
// Depends on pbi_pkg and the padded_bucket_index_build RTL.
`timescale 1ns / 100ps

module tb_padded_bucket_index_build;
	import pbi_pkg::*;

	typedef struct {
		status_t     st;
		logic [12:0] val;
		logic [10:0] bc;
		logic [23:0] len;
	} result_t;

	typedef struct {
		bit          is_cfg;
		cfg_idx_t    ci;
		logic [23:0] cd;
		req_t        rq;
		logic [23:0] cx;
		logic [15:0] hw;
		logic [12:0] ix;
		bit          known;
		result_t     ex;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [23:0] obj_center_x;
	logic [15:0] obj_half_width;
	logic [12:0] read_index;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [12:0] value;
	logic [10:0] bucket_count;
	logic [23:0] level_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	padded_bucket_index_build DUT (.*);

	// predictor state
	logic signed [23:0] obj_x [MAX_OBJECTS];
	logic [15:0]        obj_hw [MAX_OBJECTS];
	int                 n_obj = 0;
	longint             lo_edge = 0, hi_edge = 0;
	int                 row_start [MAX_BUCKETS+1];
	int                 cell_uid [MAX_CELLS];
	int                 n_held = 0;
	longint             bw_reg = 1920, bs_reg = 480, len_reg = 0;

	result_t pending_results [$];
	row_t    dir_rows [$];
	int      errors = 0;
	int      idle_pct = 0, stall_pct = 0;
	int      hold_cnt = 0;
	bit      hold_req = 0;
	int      sent = 0;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic longint sat24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	function automatic void obj_span(int i, longint org, longint w, longint nb,
		output longint lo, output longint hi);
		lo = (sat24(longint'(obj_x[i]) - longint'(obj_hw[i])) - org) / w - 1;
		hi = (sat24(longint'(obj_x[i]) + longint'(obj_hw[i])) - org) / w + 1;
		if (lo < 0)
			lo = 0;
		if (hi > nb - 1)
			hi = nb - 1;
	endfunction

	function automatic status_t rebuild_index(output int nb_o);
		longint w, org, nb, lo, hi;
		int cnt [MAX_BUCKETS];
		int cur [MAX_BUCKETS];
		int s;
		status_t st;
		st = ST_OK;
		if (n_obj == 0) begin
			row_start[0] = 0;
			row_start[1] = 0;
			n_held = 1;
			nb_o = 1;
			return ST_OK;
		end
		w = (bw_reg == 0) ? 1 : bw_reg;
		org = lo_edge - bs_reg;
		if (len_reg <= 0)
			len_reg = sat24(hi_edge + 5 * bs_reg);
		nb = (hi_edge - org) / w + 2;
		if (nb > MAX_BUCKETS) begin
			nb = MAX_BUCKETS;
			st = ST_OVFL;
		end
		for (int b = 0; b < nb; b++)
			cnt[b] = 0;
		for (int i = 0; i < n_obj; i++) begin
			obj_span(i, org, w, nb, lo, hi);
			for (longint b = lo; b <= hi; b++)
				cnt[b]++;
		end
		row_start[0] = 0;
		for (int b = 0; b < nb; b++) begin
			s = row_start[b] + cnt[b];
			if (s > MAX_CELLS) begin
				s = MAX_CELLS;
				st = ST_OVFL;
			end
			row_start[b+1] = s;
			cur[b] = row_start[b];
		end
		for (int i = 0; i < n_obj; i++) begin
			obj_span(i, org, w, nb, lo, hi);
			for (longint b = lo; b <= hi; b++) begin
				if (cur[b] < row_start[b+1]) begin
					cell_uid[cur[b]] = i % 1024;
					cur[b]++;
				end
			end
		end
		n_held = int'(nb);
		nb_o = int'(nb);
		return st;
	endfunction

	function automatic result_t bucket_index_apply(req_t rq, logic [23:0] cx,
		logic [15:0] hw, logic [12:0] ix);
		result_t r;
		longint l, rt;
		int nb;
		r = '{ST_OK, 13'd0, 11'd0, 24'd0};
		case (rq)
			REQ_ADD: begin
				if (n_obj >= MAX_OBJECTS) begin
					r.st = ST_FULL;
				end else begin
					obj_x[n_obj] = cx;
					obj_hw[n_obj] = hw;
					l = sat24(longint'($signed(cx)) - longint'(hw));
					rt = sat24(longint'($signed(cx)) + longint'(hw));
					if (n_obj == 0 || l < lo_edge)
						lo_edge = l;
					if (n_obj == 0 || rt > hi_edge)
						hi_edge = rt;
					r.val = 13'(n_obj);
					n_obj++;
				end
			end
			REQ_FINALIZE: begin
				r.st = rebuild_index(nb);
				r.bc = 11'(nb);
				r.len = len_reg[23:0];
			end
			REQ_READ_ROW: begin
				if (ix <= n_held && ix <= MAX_BUCKETS)
					r.val = 13'(row_start[ix]);
				else
					r.st = ST_RANGE;
			end
			default: begin
				if (ix < row_start[n_held] && ix < MAX_CELLS)
					r.val = 13'(cell_uid[ix]);
				else
					r.st = ST_RANGE;
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(row_t rw);
		dir_rows = {dir_rows, rw};
	endfunction

	task automatic send_req(req_t rq, logic [23:0] cx, logic [15:0] hw, logic [12:0] ix,
		bit known, result_t ex);
		result_t r;
		in_valid <= 1'b1;
		req_type <= rq;
		obj_center_x <= cx;
		obj_half_width <= hw;
		read_index <= ix;
		do
			@(posedge clk);
		while (in_stall);
		r = bucket_index_apply(rq, cx, hw, ix);
		if (!known)
			ex = r;
		pending_results = {pending_results, ex};
		sent++;
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic send_rand(req_t rq, logic [23:0] cx, logic [15:0] hw, logic [12:0] ix);
		send_req(rq, cx, hw, ix, 1'b0, '{ST_OK, 13'd0, 11'd0, 24'd0});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t ci, logic [23:0] cd);
		cfg_valid <= 1'b1;
		cfg_index <= ci;
		cfg_data <= cd;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (ci)
			CFG_BUCKET_WIDTH: bw_reg = cd[15:0];
			CFG_BLOCK_SIZE:   bs_reg = cd[15:0];
			CFG_LENGTH:       len_reg = longint'($signed(cd));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic row_t r_req(req_t rq, logic [23:0] cx, logic [15:0] hw,
		logic [12:0] ix);
		return '{1'b0, CFG_NONE, 24'd0, rq, cx, hw, ix, 1'b0, '{ST_OK, 13'd0, 11'd0, 24'd0}};
	endfunction

	function automatic row_t r_chk(req_t rq, logic [23:0] cx, logic [15:0] hw,
		logic [12:0] ix, status_t st, logic [12:0] v, logic [10:0] bc, logic [23:0] len);
		return '{1'b0, CFG_NONE, 24'd0, rq, cx, hw, ix, 1'b1, '{st, v, bc, len}};
	endfunction

	function automatic row_t r_cfg(cfg_idx_t ci, logic [23:0] cd);
		return '{1'b1, ci, cd, REQ_ADD, 24'd0, 16'd0, 13'd0, 1'b0,
			'{ST_OK, 13'd0, 11'd0, 24'd0}};
	endfunction

	// receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: st=%0d val=%0d bc=%0d len=%0h",
						status, value, bucket_count, level_length);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || value !== e.val || bucket_count !== e.bc ||
					level_length !== e.len) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %0d/%0d/%0d/%0h got %0d/%0d/%0d/%0h",
							e.st, e.val, e.bc, e.len, status, value, bucket_count,
							level_length);
				end
			end
		end
	end

	initial begin
		#2_000_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int nadd, nrd, total;
		logic signed [23:0] base;
		row_t rw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 2'd0;
		obj_center_x = 24'd0;
		obj_half_width = 16'd0;
		read_index = 13'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 2'd0;
		cfg_data = 24'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		add_row(r_chk(REQ_READ_ROW, 0, 0, 0, ST_OK, 0, 0, 0));
		add_row(r_chk(REQ_READ_ROW, 0, 0, 1, ST_RANGE, 0, 0, 0));
		add_row(r_chk(REQ_READ_CELL, 0, 0, 0, ST_RANGE, 0, 0, 0));
		add_row(r_chk(REQ_FINALIZE, 0, 0, 0, ST_OK, 0, 1, 0));
		add_row(r_chk(REQ_READ_ROW, 0, 0, 1, ST_OK, 0, 0, 0));
		add_row(r_chk(REQ_ADD, 24'd0, 16'd0, 0, ST_OK, 0, 0, 0));
		add_row(r_chk(REQ_ADD, 24'h7FFFFF, 16'hFFFF, 0, ST_OK, 1, 0, 0));
		add_row(r_chk(REQ_ADD, 24'h800000, 16'hFFFF, 0, ST_OK, 2, 0, 0));
		add_row(r_chk(REQ_FINALIZE, 0, 0, 0, ST_OVFL, 0, 1024, 24'h7FFFFF));
		add_row(r_req(REQ_READ_ROW, 0, 0, 1024));
		add_row(r_chk(REQ_READ_ROW, 0, 0, 1025, ST_RANGE, 0, 0, 0));
		add_row(r_req(REQ_READ_CELL, 0, 0, 0));
		add_row(r_chk(REQ_READ_CELL, 0, 0, 13'h1FFF, ST_RANGE, 0, 0, 0));
		add_row(r_cfg(CFG_BUCKET_WIDTH, 24'd0));
		add_row(r_cfg(CFG_BLOCK_SIZE, 24'd1));
		add_row(r_cfg(CFG_LENGTH, 24'h800000));
		add_row(r_cfg(CFG_NONE, 24'hABCDEF));
		repeat (4) add_row(r_req(REQ_ADD, 24'h800064, 16'hFFFF, 0));
		add_row(r_req(REQ_FINALIZE, 0, 0, 0));
		add_row(r_req(REQ_READ_ROW, 0, 0, 1024));
		add_row(r_req(REQ_READ_ROW, 0, 0, 4096));
		add_row(r_req(REQ_READ_CELL, 0, 0, 4095));
		add_row(r_req(REQ_READ_CELL, 0, 0, 0));

		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			if (rw.is_cfg) begin
				drain();
				write_cfg(rw.ci, rw.cd);
			end else begin
				send_req(rw.rq, rw.cx, rw.hw, rw.ix, rw.known, rw.ex);
			end
		end

		for (int ph = 0; sent < 650; ph++) begin
			drain();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 67; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 67; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			write_cfg(CFG_BUCKET_WIDTH,
				(ph % 5 == 0) ? 24'd65535 : 24'($urandom_range(1024, 65535)));
			case (ph % 6)
				0: write_cfg(CFG_BLOCK_SIZE, 24'd1);
				1: write_cfg(CFG_BLOCK_SIZE, 24'd65535);
				default: write_cfg(CFG_BLOCK_SIZE, 24'($urandom_range(1, 65535)));
			endcase
			case (ph % 5)
				0: write_cfg(CFG_LENGTH, 24'd0);
				1: write_cfg(CFG_LENGTH, 24'h7FFFFF);
				2: write_cfg(CFG_LENGTH, 24'h800000);
				default: write_cfg(CFG_LENGTH, 24'($urandom()));
			endcase
			if (ph == 5)
				hold_req = 1'b1;
			base = 24'($urandom());
			nadd = $urandom_range(2, 16);
			for (int k = 0; k < nadd; k++)
				send_rand(REQ_ADD, ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
					24'(base + $urandom_range(0, 200000)),
					($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
					16'($urandom_range(0, 2047)), 13'($urandom()));
			send_rand(REQ_FINALIZE, 24'($urandom()), 16'($urandom()), 13'($urandom()));
			nrd = $urandom_range(4, 14);
			for (int k = 0; k < nrd; k++) begin
				total = row_start[n_held];
				case ($urandom_range(0, 9))
					0: send_rand(req_t'($urandom_range(0, 3)), 24'($urandom()),
						16'($urandom_range(0, 2047)), 13'($urandom()));
					1, 2, 3, 4: send_rand(REQ_READ_ROW, 24'($urandom()), 16'($urandom()),
						13'($urandom_range(0, n_held)));
					default: send_rand(REQ_READ_CELL, 24'($urandom()), 16'($urandom()),
						(total > 0) ? 13'($urandom_range(0, total - 1)) :
						13'($urandom()));
				endcase
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
